>>> hw/rtl/url_percent_decoder_top_defines.svh
// Assertion helpers for the percent decoder.
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset only.
`define UPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define UPD_ASSERT(lbl, clk, rst_n, prop, msg)

`define UPD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  localparam int CountBitsDefault  = 16;
  localparam int QueueDepthDefault = 4;
  localparam int MaxResults        = 3;

  localparam logic [15:0] CapacityReset = 16'd256;

  // Register index of out_capacity
  localparam logic RegOutCapacity = 1'b0;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } escape_phase_e;

  typedef enum logic [1:0] {
    CAND_NONE = 2'd0,
    CAND_DATA = 2'd1,
    CAND_TERM = 2'd2,
    CAND_ESC  = 2'd3
  } cand_kind_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] count;
  } result_t;

  // One queue entry: the results of one input byte, res[0] first.
  typedef struct packed {
    logic [1:0]              num;
    result_t [MaxResults-1:0] res;
  } bundle_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/url_percent_decoder_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------------------
// input     | push / full        | in_byte_i
// results   | empty / pop        | out_byte_o, is_last_o, written_count_o
// config    | psel/penable/pready| paddr (3 b), pwdata/prdata (32 b)
//
// One input byte is taken per cycle while the bundle queue has room.
// Each byte yields up to three results; the back end hands out one per cycle
// while pop is held, so a run of escape failures stalls input via full once
// the queue fills. Reset (rst_ni, async, low) empties the queue and loads
// capacity 256. Results are registered in the bundle queue before output.

`include "url_percent_decoder_top_defines.svh"

module url_percent_decoder_top #(
  parameter int COUNT_BITS  = upd_pkg::CountBitsDefault,
  parameter int QUEUE_DEPTH = upd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // encoded input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  // decoded output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        is_last_o,
  output logic [15:0] written_count_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import upd_pkg::*;

  bundle_t q_wdata, q_head;
  logic    q_push, q_full, q_pop, q_empty;

  // writes always complete in their access cycle
  assign pready = 1'b1;

  // Front end: escape tracking, capacity accounting, register file.
  upd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_byte_i (in_byte_i),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // Short queue of result bundles decoupling the two halves.
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Back end: one result per transfer out of the head bundle.
  upd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .is_last_o       (is_last_o),
    .written_count_o (written_count_o)
  );

  // A full queue always has a result to offer.
  `UPD_ASSERT(a_full_not_empty, clk_i, rst_ni, full |-> !empty, "full with nothing to pop")
  // Terminator carries a zero byte.
  `UPD_ASSERT(a_term_zero, clk_i, rst_ni, (!empty && is_last_o) |-> (out_byte_o == 8'h00), "terminator byte not zero")
  // Count is only carried on the terminator.
  `UPD_ASSERT(a_count_on_last, clk_i, rst_ni, (!empty && !is_last_o) |-> (written_count_o == 16'h0000), "count on a data result")
  // Queue is clear on the edge after reset has been seen.
  `UPD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (empty && !full), "queue not clear after reset")

endmodule

>>> hw/rtl/upd_front.sv
`timescale 1ns / 1ps

module upd_front #(
  parameter int COUNT_BITS = upd_pkg::CountBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input byte stream
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte_i,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  // queue side
  input  logic             q_full_i,
  output logic             q_push_o,
  output upd_pkg::bundle_t q_data_o
);

  import upd_pkg::*;

  localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_BITS) - 64'd1);

  function automatic logic [COUNT_BITS-1:0] capped(logic [15:0] cap);
    logic [31:0] wide;
    wide = {16'b0, cap};
    return (wide > CountMask) ? CountMask[COUNT_BITS-1:0] : wide[COUNT_BITS-1:0];
  endfunction

  logic [15:0]           cap_q;
  escape_phase_e         phase_q, phase_d, phase_base;
  logic [7:0]            held_q, held_d;
  logic [COUNT_BITS-1:0] slots_q, slots_d;
  logic [COUNT_BITS-1:0] bw_q, bw_d;

  cand_kind_e            kind  [MaxResults];
  logic [7:0]            cbyte [MaxResults];

  logic [4:0]            hex_in, hex_held;
  logic                  accept, cfg_wr;
  logic [MaxResults-1:0] room;
  bundle_t               bundle;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegOutCapacity);
  assign prdata = (paddr[2] == RegOutCapacity) ? {16'b0, cap_q} : 32'b0;

  assign hex_in   = hex_decode(in_byte_i);
  assign hex_held = hex_decode(held_q);

  // Data candidate k is written only while more than k+1 slots are free
  always_comb begin
    for (int k = 0; k < MaxResults; k++) begin
      room[k] = slots_q > COUNT_BITS'(k + 1);
    end
  end

  // Classification: escape tracking and candidate results
  always_comb begin
    cand_kind_e pk;
    logic [7:0] pb;
    for (int k = 0; k < MaxResults; k++) begin
      kind[k]  = CAND_NONE;
      cbyte[k] = ChNul;
    end
    phase_base = PH_IDLE;
    held_d     = held_q;
    // ordinary treatment of the incoming byte
    pb = in_byte_i;
    if (in_byte_i == ChNul) begin
      pk = CAND_TERM;
    end else if (in_byte_i == ChPlus) begin
      pk = CAND_DATA;
      pb = ChSpace;
    end else if (in_byte_i == ChPercent) begin
      pk = CAND_ESC;
    end else begin
      pk = CAND_DATA;
    end
    case (phase_q)
      PH_PCT: begin
        if (hex_in[4]) begin
          held_d     = in_byte_i;
          phase_base = PH_DIGIT;
        end else begin
          kind[0]  = CAND_DATA;
          cbyte[0] = ChPercent;
          kind[1]  = pk;
          cbyte[1] = pb;
        end
      end
      PH_DIGIT: begin
        if (hex_in[4]) begin
          kind[0]  = CAND_DATA;
          cbyte[0] = {hex_held[3:0], hex_in[3:0]};
        end else begin
          // the held digit is always a hex character, so plain data
          kind[0]  = CAND_DATA;
          cbyte[0] = ChPercent;
          kind[1]  = CAND_DATA;
          cbyte[1] = held_q;
          kind[2]  = pk;
          cbyte[2] = pb;
        end
      end
      default: begin
        kind[0]  = pk;
        cbyte[0] = pb;
      end
    endcase
  end

  // Capacity accounting and result assembly
  always_comb begin
    logic [1:0]            nd;
    logic [1:0]            nr;
    logic                  term;
    logic [COUNT_BITS-1:0] tcount;
    logic [31:0]           tcount_w;
    nd       = 2'd0;
    nr       = 2'd0;
    term     = 1'b0;
    tcount   = '0;
    tcount_w = '0;
    phase_d  = phase_base;
    bundle   = '0;
    for (int k = 0; k < MaxResults; k++) begin
      case (kind[k])
        CAND_DATA: begin
          if (room[nd]) begin
            bundle.res[nr].data = cbyte[k];
            nr = nr + 2'd1;
            nd = nd + 2'd1;
          end
        end
        CAND_ESC: begin
          if (room[nd]) begin
            phase_d = PH_PCT;
          end
        end
        CAND_TERM: begin
          term = 1'b1;
          if (slots_q == '0) begin
            tcount = bw_q;
          end else begin
            tcount = bw_q + COUNT_BITS'(nd) + COUNT_BITS'(1);
          end
          tcount_w             = 32'(tcount);
          bundle.res[nr].last  = 1'b1;
          bundle.res[nr].count = tcount_w[15:0];
          nr = nr + 2'd1;
        end
        default: begin
        end
      endcase
    end
    bundle.num = nr;
    if (term) begin
      slots_d = capped(cap_q);
      bw_d    = '0;
      phase_d = PH_IDLE;
    end else begin
      slots_d = slots_q - COUNT_BITS'(nd);
      bw_d    = bw_q + COUNT_BITS'(nd);
    end
  end

  assign q_push_o = accept && (bundle.num != 2'd0);
  assign q_data_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapacityReset;
      phase_q <= PH_IDLE;
      held_q  <= ChNul;
      slots_q <= capped(CapacityReset);
      bw_q    <= '0;
    end else begin
      if (cfg_wr) begin
        cap_q <= pwdata[15:0];
      end
      if (accept) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        slots_q <= slots_d;
        bw_q    <= bw_d;
      end else if (cfg_wr && bw_q == '0 && phase_q != PH_PCT && phase_q != PH_DIGIT) begin
        slots_q <= capped(pwdata[15:0]);
      end
    end
  end

endmodule

>>> hw/rtl/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue #(
  parameter int DEPTH = upd_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  upd_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output upd_pkg::bundle_t head_o,
  output logic             empty_o
);

  import upd_pkg::*;

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  bundle_t              mem_q [DEPTH];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  function automatic logic [PtrBits-1:0] bump(logic [PtrBits-1:0] p);
    return (p == PtrBits'(DEPTH - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= bump(wr_q);
      end
      if (do_pop) begin
        rd_q <= bump(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

endmodule

>>> hw/rtl/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  // queue side
  input  upd_pkg::bundle_t head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  // result stream
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte_o,
  output logic             is_last_o,
  output logic [15:0]      written_count_o
);

  import upd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       xfer, final_one;
  result_t    cur;

  assign cur             = head_i.res[idx_q];
  assign empty           = q_empty_i;
  assign out_byte_o      = cur.data;
  assign is_last_o       = cur.last;
  assign written_count_o = cur.count;

  assign xfer      = pop && !q_empty_i;
  assign final_one = (idx_q == head_i.num - 2'd1);
  assign q_pop_o   = xfer && final_one;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = final_one ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
